### hdl/cscan_disk_scheduler_top_macros.svh
// Assertion macros for the C-SCAN scheduler checker.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef CSCAN_DISK_SCHEDULER_TOP_MACROS_SVH
`define CSCAN_DISK_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cscan scheduler check failed");

// Next-cycle implication, checked outside reset.
`define CSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cscan scheduler check failed");

`endif

### hdl/csd_pkg.sv
// Shared types and constants for the C-SCAN disk scheduler.
// No dependencies; every other source file but the assertion macros header imports this package.
package csd_pkg;

    localparam int MAX_REQUESTS = 32;
    localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
    localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CYL_W        = 16;
    localparam int DIST_W       = 22;

    localparam logic [CYL_W-1:0]  CYL_COUNT_RESET = CYL_W'(200);
    localparam logic [DIST_W-1:0] DIST_MAX        = {DIST_W{1'b1}};

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_START = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [CYL_W-1:0] cylinder;
    } t_item;

    typedef struct packed {
        logic [CYL_W-1:0]  from_cylinder;
        logic [CYL_W-1:0]  to_cylinder;
        logic [DIST_W-1:0] total_distance;
        logic              last_move;
        logic              requests_dropped;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // insert the item's cylinder into the sorted store
        logic start;       // capture head, clear index and distance
        logic step;        // advance the index
        logic mark_split;  // the index now equals the count of lower requests
        logic emit_entry;  // move to the entry at the index
        logic emit_top;    // move to the top cylinder and rewind the index
        logic last;        // this move ends the schedule
        logic finish;      // clear request count and overflow flag
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic idx_below_n;
        logic entry_below_head;
        logic last_low;
        logic split_zero;
    } t_status;

endpackage

### hdl/csd_ctrl.sv
// Sequencer for the C-SCAN scheduler: load, split search, upper sweep, lower sweep.
// Depends on csd_pkg for the command and status structs.
module csd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  csd_pkg::t_item     i_item,
    input  csd_pkg::t_status   i_status,
    output csd_pkg::t_cmd      o_cmd,
    output logic               busy
);
    import csd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPPER,
        S_LOWER
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_item.mode == MODE_START) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SCAN;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                // Walk the sorted store until the first request at or above the head.
                if (i_status.idx_below_n && i_status.entry_below_head) begin
                    o_cmd.step = 1'b1;
                end else begin
                    o_cmd.mark_split = 1'b1;
                    n_state          = S_UPPER;
                end
            end
            S_UPPER: begin
                if (i_status.idx_below_n) begin
                    o_cmd.emit_entry = 1'b1;
                    o_cmd.step       = 1'b1;
                end else begin
                    o_cmd.emit_top = 1'b1;
                    o_cmd.last     = i_status.split_zero;
                    if (i_status.split_zero) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_LOWER;
                    end
                end
            end
            S_LOWER: begin
                o_cmd.emit_entry = 1'b1;
                o_cmd.step       = 1'b1;
                o_cmd.last       = i_status.last_low;
                if (i_status.last_low) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

### hdl/csd_datapath.sv
// Datapath of the C-SCAN scheduler: sorted request cells, counters, distance
// accumulator, result register and the cylinder count register. Uses csd_pkg.
module csd_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  csd_pkg::t_item             i_item,
    input  csd_pkg::t_cmd              i_cmd,
    input  logic                       i_cfg_we,
    input  logic [csd_pkg::CYL_W-1:0]  i_cfg_data,
    output csd_pkg::t_status           o_status,
    output csd_pkg::t_result           o_result,
    output logic                       o_result_strobe
);
    import csd_pkg::*;

    logic [CYL_W-1:0]  r_store [MAX_REQUESTS];
    logic [CNT_W-1:0]  r_count;
    logic              r_overflow;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_split;
    logic [CYL_W-1:0]  r_head;
    logic [DIST_W-1:0] r_dist;
    logic [CYL_W-1:0]  r_cyl_count;
    t_result           r_result;
    logic              r_strobe;

    logic [MAX_REQUESTS-1:0] gt;
    logic              full;
    logic [CYL_W-1:0]  entry;
    logic [CYL_W-1:0]  top;
    logic [CYL_W-1:0]  to_cyl;
    logic [CYL_W-1:0]  diff;
    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] n_dist;
    logic              emit;

    assign full = (r_count == CNT_W'(MAX_REQUESTS));

    // The store is kept sorted: each cell holding a value above the new one
    // shifts up by one, and the first such cell (or the fill slot) takes it.
    genvar g;
    generate
        for (g = 0; g < MAX_REQUESTS; g++) begin : g_cell
            logic             prev_gt;
            logic [CYL_W-1:0] prev_val;

            assign gt[g] = (CNT_W'(g) < r_count) && (r_store[g] > i_item.cylinder);

            if (g == 0) begin : g_first
                assign prev_gt  = 1'b0;
                assign prev_val = i_item.cylinder;
            end else begin : g_rest
                assign prev_gt  = gt[g-1];
                assign prev_val = r_store[g-1];
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.load && !full && (gt[g] || (CNT_W'(g) == r_count))) begin
                    r_store[g] <= prev_gt ? prev_val : i_item.cylinder;
                end
            end
        end
    endgenerate

    assign entry = r_store[r_idx[IDX_W-1:0]];
    assign top   = r_cyl_count - CYL_W'(1);

    assign o_status.idx_below_n      = (r_idx < r_count);
    assign o_status.entry_below_head = (entry < r_head);
    assign o_status.last_low         = ((r_idx + CNT_W'(1)) == r_split);
    assign o_status.split_zero       = (r_split == '0);

    assign emit   = i_cmd.emit_entry || i_cmd.emit_top;
    assign to_cyl = i_cmd.emit_top ? top : entry;
    assign diff   = (to_cyl >= r_head) ? (to_cyl - r_head) : (r_head - to_cyl);
    assign sum    = {1'b0, r_dist} + (DIST_W+1)'(diff);
    assign n_dist = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_idx       <= '0;
            r_split     <= '0;
            r_cyl_count <= CYL_COUNT_RESET;
            r_strobe    <= 1'b0;
        end else begin
            r_strobe <= emit;
            if (i_cfg_we) begin
                r_cyl_count <= i_cfg_data;
            end
            if (i_cmd.load) begin
                if (full) begin
                    r_overflow <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.start || i_cmd.emit_top) begin
                r_idx <= '0;
            end else if (i_cmd.step) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (i_cmd.mark_split) begin
                r_split <= r_idx;
            end
            if (i_cmd.finish) begin
                r_count    <= '0;
                r_overflow <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_head <= i_item.cylinder;
            r_dist <= '0;
        end else if (emit) begin
            r_head <= to_cyl;
            r_dist <= n_dist;
        end
        if (emit) begin
            r_result.from_cylinder    <= r_head;
            r_result.to_cylinder      <= to_cyl;
            r_result.total_distance   <= n_dist;
            r_result.last_move        <= i_cmd.last;
            r_result.requests_dropped <= r_overflow;
        end
    end

    assign o_result        = r_result;
    assign o_result_strobe = r_strobe;

endmodule

### hdl/cscan_disk_scheduler_top.sv
// C-SCAN disk head scheduler, top level.
// Instantiates csd_ctrl and csd_datapath; types come from csd_pkg.
//
// Usage:
//   Command channel: an item transfers on a rising edge with start high and
//   busy low. A load item (mode 0) inserts its cylinder into a sorted store
//   of 32 requests and leaves busy low, so loads may stream one per cycle.
//   Loads beyond capacity are dropped and flagged on the next run.
//   A start item (mode 1) carries the head position and raises busy.
//   Results: each move is shown for exactly one cycle with o_result_strobe
//   high; the receiver cannot stall the block.
//   Order of a run with n stored requests of which s lie below the head:
//   the split search walks past the s lower entries, then one move leaves per
//   cycle (n-s upper moves, the move to the top cylinder, s lower moves), each
//   result registered and shown in the cycle after its move. busy drops in the
//   same cycle as the last result is shown. The search walks the sorted store
//   one entry a cycle, and the distance adder gives one move a cycle.
//   Configuration: cylinder_count is written on i_cfg_valid and o_cfg_ready,
//   which is high whenever busy is low.
//   Reset: cylinder_count returns to 200, the request count and overflow
//   flag clear, and no result is pending.
module cscan_disk_scheduler_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  csd_pkg::t_item             i_item,
    output logic                       busy,
    input  logic                       i_cfg_valid,
    input  logic [csd_pkg::CYL_W-1:0]  i_cfg_data,
    output logic                       o_cfg_ready,
    output csd_pkg::t_result           o_result,
    output logic                       o_result_strobe
);
    import csd_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    ctrl_busy;

    csd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (ctrl_busy)
    );

    csd_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (i_item),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_valid && !ctrl_busy),
        .i_cfg_data      (i_cfg_data),
        .o_status        (status),
        .o_result        (o_result),
        .o_result_strobe (o_result_strobe)
    );

    assign busy        = ctrl_busy;
    assign o_cfg_ready = !ctrl_busy;

endmodule

### hdl/csd_checker.sv
// Port-level checks for the C-SCAN scheduler, bound to the top level.
// Depends on csd_pkg and the assertion macros header.
`include "cscan_disk_scheduler_top_macros.svh"

module csd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input csd_pkg::t_item             i_item,
    input logic                       busy,
    input logic                       o_cfg_ready,
    input csd_pkg::t_result           o_result,
    input logic                       o_result_strobe
);
    import csd_pkg::*;

    // A start transfer always begins a run.
    `CSD_ASSERT_NEXT(a_start_busy, start && !busy && i_item.mode == MODE_START, busy)

    // A load transfer never begins a run.
    `CSD_ASSERT_NEXT(a_load_idle, start && !busy && i_item.mode == MODE_LOAD, !busy)

    // The final move ends the stream of results.
    `CSD_ASSERT_NEXT(a_last_ends, o_result_strobe && o_result.last_move, !o_result_strobe)

    // Any move that is not the last one leaves the run in progress.
    `CSD_ASSERT_NOW(a_more_moves, o_result_strobe && !o_result.last_move, busy)

    // Configuration is refused while a run is in progress.
    `CSD_ASSERT_NOW(a_cfg_locked, busy, !o_cfg_ready)

endmodule

bind cscan_disk_scheduler_top csd_checker u_csd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .i_item          (i_item),
    .busy            (busy),
    .o_cfg_ready     (o_cfg_ready),
    .o_result        (o_result),
    .o_result_strobe (o_result_strobe)
);

### bench/tb_cscan_disk_scheduler_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for cscan_disk_scheduler_top: a queue-fed driver, a result monitor
// and a C-SCAN move predictor. Depends on csd_pkg and the scheduler RTL only.
module tb_cscan_disk_scheduler_top;
    import csd_pkg::*;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    t_item            i_item      = '0;
    logic             busy;
    logic             i_cfg_valid = 1'b0;
    logic [CYL_W-1:0] i_cfg_data  = '0;
    logic             o_cfg_ready;
    t_result          o_result;
    logic             o_result_strobe;

    t_item            cmd_queue[$];
    t_result          moves_due[$];
    logic [CYL_W-1:0] pending_cyls[$];
    logic             overflow_seen = 1'b0;
    logic [CYL_W-1:0] cyl_count     = CYL_COUNT_RESET;
    int               idle_pct      = 0;
    int               mismatches    = 0;

    cscan_disk_scheduler_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_item          (i_item),
        .busy            (busy),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_cfg_ready     (o_cfg_ready),
        .o_result        (o_result),
        .o_result_strobe (o_result_strobe)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
    endtask

    task automatic add_move(input logic [CYL_W-1:0] from_cyl, input logic [CYL_W-1:0] to_cyl,
                            inout int unsigned run_dist, input logic last);
        t_result r;
        run_dist += (from_cyl > to_cyl) ? from_cyl - to_cyl : to_cyl - from_cyl;
        if (run_dist > DIST_MAX) begin
            run_dist = DIST_MAX;
        end
        r.from_cylinder    = from_cyl;
        r.to_cylinder      = to_cyl;
        r.total_distance   = run_dist[DIST_W-1:0];
        r.last_move        = last;
        r.requests_dropped = overflow_seen;
        moves_due.push_back(r);
    endtask

    // Loads collect requests; a start sorts them and queues the sweep up to the
    // top cylinder followed by the wrapped pass over the requests below the head.
    task automatic schedule_moves(input t_item it);
        logic [CYL_W-1:0] sorted[$];
        logic [CYL_W-1:0] v;
        logic [CYL_W-1:0] top;
        logic [CYL_W-1:0] head;
        int               split;
        int               j;
        int unsigned      run_dist;
        if (it.mode == MODE_LOAD) begin
            if (pending_cyls.size() < MAX_REQUESTS) begin
                pending_cyls.push_back(it.cylinder);
            end else begin
                overflow_seen = 1'b1;
            end
            return;
        end
        foreach (pending_cyls[i]) begin
            v = pending_cyls[i];
            j = 0;
            while (j < sorted.size() && sorted[j] <= v) j++;
            sorted.insert(j, v);
        end
        split = 0;
        while (split < sorted.size() && sorted[split] < it.cylinder) split++;
        top      = cyl_count - 1'b1;
        head     = it.cylinder;
        run_dist = 0;
        for (int i = split; i < sorted.size(); i++) begin
            add_move(head, sorted[i], run_dist, 1'b0);
            head = sorted[i];
        end
        add_move(head, top, run_dist, split == 0);
        head = top;
        for (int i = 0; i < split; i++) begin
            add_move(head, sorted[i], run_dist, i == split - 1);
            head = sorted[i];
        end
        pending_cyls.delete();
        overflow_seen = 1'b0;
    endtask

    // Command driver: an item transfers on an edge with start high and busy low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (start) begin
                schedule_moves(i_item);
            end
            if (cmd_queue.size() != 0 && $urandom_range(1, 100) > idle_pct) begin
                start  <= 1'b1;
                i_item <= cmd_queue.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Result monitor: every strobed move is compared with the oldest expected move.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_result_strobe) begin
            if (moves_due.size() == 0) begin
                report_mismatch("unexpected move to_cylinder", o_result.to_cylinder, -1);
            end else begin
                want = moves_due.pop_front();
                if (o_result.from_cylinder !== want.from_cylinder)
                    report_mismatch("from_cylinder", o_result.from_cylinder,
                                    want.from_cylinder);
                if (o_result.to_cylinder !== want.to_cylinder)
                    report_mismatch("to_cylinder", o_result.to_cylinder, want.to_cylinder);
                if (o_result.total_distance !== want.total_distance)
                    report_mismatch("total_distance", o_result.total_distance,
                                    want.total_distance);
                if (o_result.last_move !== want.last_move)
                    report_mismatch("last_move", o_result.last_move, want.last_move);
                if (o_result.requests_dropped !== want.requests_dropped)
                    report_mismatch("requests_dropped", o_result.requests_dropped,
                                    want.requests_dropped);
            end
        end
    end

    task automatic put(input logic mode, input logic [CYL_W-1:0] cyl);
        t_item it;
        it.mode     = mode;
        it.cylinder = cyl;
        cmd_queue.push_back(it);
    endtask

    // Mostly in-range cylinders, with zero, all ones, duplicates, the top, just past the top and full range.
    function automatic logic [CYL_W-1:0] pick_cylinder(input logic [CYL_W-1:0] prev);
        logic [CYL_W-1:0] top;
        top = cyl_count - 1'b1;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return top;
            3: return top + 1'b1;
            4: return prev;
            5: return CYL_W'($urandom);
            default: return CYL_W'($urandom_range(0, top));
        endcase
    endfunction

    task automatic queue_run(input int n_loads);
        logic [CYL_W-1:0] prev;
        prev = CYL_W'($urandom);
        for (int k = 0; k < n_loads; k++) begin
            prev = pick_cylinder(prev);
            put(MODE_LOAD, prev);
        end
        put(MODE_START, pick_cylinder(prev));
    endtask

    // Returns once every item has transferred and every expected move has arrived,
    // then lets the scheduler settle back to idle.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (cmd_queue.size() != 0 || start || moves_due.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cylinders(input logic [CYL_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cyl_count = value;
    endtask

    task automatic random_phase(input int n_items, input int pct);
        int queued;
        int n;
        idle_pct = pct;
        queued   = 0;
        while (queued < n_items) begin
            n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8)
                                           : $urandom_range(9, MAX_REQUESTS + 3);
            queue_run(n);
            queued += n + 1;
        end
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed runs at the reset cylinder count.
        put(MODE_START, 16'd0);
        put(MODE_LOAD, 16'd65535);
        put(MODE_LOAD, 16'd0);
        put(MODE_LOAD, 16'd199);
        put(MODE_LOAD, 16'd100);
        put(MODE_LOAD, 16'd200);
        put(MODE_START, 16'd100);
        put(MODE_LOAD, 16'd50);
        put(MODE_LOAD, 16'd150);
        put(MODE_START, 16'd65535);
        put(MODE_LOAD, 16'd7);
        put(MODE_LOAD, 16'd7);
        put(MODE_LOAD, 16'd3);
        put(MODE_START, 16'd10);
        put(MODE_LOAD, 16'd199);
        put(MODE_START, 16'd199);
        put(MODE_LOAD, 16'hAAAA);
        put(MODE_LOAD, 16'h5555);
        put(MODE_START, 16'd0);
        wait_drained();

        // The first run after the widest setting overfills the request store.
        write_cylinders(16'hFFFF);
        queue_run(MAX_REQUESTS + 2);
        random_phase(50, 0);
        write_cylinders(16'd2);
        random_phase(40, 76);
        write_cylinders(16'd0);
        random_phase(40, 25);
        write_cylinders(16'd1);
        random_phase(25, 0);
        write_cylinders(CYL_W'($urandom_range(3, 4000)));
        queue_run(MAX_REQUESTS + 1);
        random_phase(50, 76);

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/csd_pkg.sv
hdl/csd_ctrl.sv
hdl/csd_datapath.sv
hdl/cscan_disk_scheduler_top.sv
hdl/csd_checker.sv
bench/tb_cscan_disk_scheduler_top.sv
